FILE: rtl/hlce_pkg.sv
// Package for the HP lattice contact energy core.
// Holds the controller state type, command/status structs and counter limits.
// No dependencies.
package hlce_pkg;

  // Saturation limits of the pair counters
  localparam logic [7:0] ADJ_MAX  = 8'd255;
  localparam logic [6:0] BOND_MAX = 7'd127;

  // Clamp window of the energy result
  localparam logic signed [8:0] ENERGY_MIN = -9'sd128;
  localparam logic signed [8:0] ENERGY_MAX = 9'sd63;

  // Bonded term counts only from this chain length on
  localparam int unsigned MIN_CHAIN = 3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the request fields, restart the scan index
    logic set_ovf;  // request dropped, store is full
    logic rd_en;    // read the stored site at the scan index
    logic wr_en;    // store the request, update chain counters
    logic emit;     // drive the result and clear the conformation
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;       // store holds the maximum number of monomers
    logic scan_done;  // all stored sites have been read
    logic last;       // captured request ends the conformation
  } dp_status_t;

endpackage

FILE: rtl/hlce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hlce_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/hlce_ctrl.sv
// Controller state machine of the HP lattice contact energy core.
// Depends on hlce_pkg (state_t, ctrl_cmd_t, dp_status_t).
module hlce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hlce_pkg::dp_status_t status,
  output hlce_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import hlce_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!status.full) begin
            state_nxt = ST_SCAN;
          end else if (status.last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_nxt = status.last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs; note status.last is the live request field while idle
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.load    = start;
        cmd.set_ovf = start & status.full;
      end
      ST_SCAN: begin
        cmd.rd_en = ~status.scan_done;
      end
      ST_WRITE: begin
        cmd.wr_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.emit = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/hlce_dp.sv
// Datapath of the HP lattice contact energy core: site store, compare,
// pair counters, result registers. Depends on hlce_pkg and hlce_ram.
module hlce_dp #(
  parameter int MAX_MONOMERS = 64,
  parameter int COORD_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hlce_pkg::ctrl_cmd_t   cmd,
  output hlce_pkg::dp_status_t  status,
  input  logic [7:0]           in_row,
  input  logic [7:0]           in_col,
  input  logic                 in_is_h,
  input  logic                 in_last,
  output logic                 out_valid,
  output logic signed [7:0]    out_energy,
  output logic                 out_collision,
  output logic                 out_overflow
);
  import hlce_pkg::*;

  // Only the low coordinate bits count; ports carry at most 8
  localparam int CW    = (COORD_BITS < 8) ? COORD_BITS : 8;
  localparam int AW    = $clog2(MAX_MONOMERS);
  localparam int CNT_W = $clog2(MAX_MONOMERS + 1);
  localparam int RW    = 2 * CW + 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_MONOMERS);
  localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_CHAIN);

  // Captured request
  logic [CW-1:0]    row_r, col_r;
  logic             h_r, last_r;

  // Conformation state
  logic [CNT_W-1:0] count_r, idx_r;
  logic [7:0]       adj_r;
  logic [6:0]       bond_r;
  logic             prev_r, coll_r, ovf_r;
  logic             rd_vld_r;

  // Result registers
  logic             out_valid_r;
  logic signed [7:0] energy_r;
  logic             coll_out_r, ovf_out_r;

  logic [RW-1:0]    rdata;
  logic [CW-1:0]    s_row, s_col;
  logic             s_kind;
  logic             same_site, adj_hit;
  logic             row_eq, col_eq;
  logic [6:0]       bond_eff;
  logic signed [8:0] diff;
  logic signed [8:0] energy_clamp;

  // True when a and b differ by exactly one
  function automatic logic one_apart(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] ax, bx;
    ax = {1'b0, a};
    bx = {1'b0, b};
    return ((ax + 1'b1) == bx) || ((bx + 1'b1) == ax);
  endfunction

  // Site store: {kind, row, col} per monomer
  hlce_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_MONOMERS)
  ) u_site_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata ({h_r, row_r, col_r}),
    .re    (cmd.rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  assign {s_kind, s_row, s_col} = rdata;

  // Compare the stored site read in the previous cycle
  assign row_eq    = (s_row == row_r);
  assign col_eq    = (s_col == col_r);
  assign same_site = rd_vld_r & row_eq & col_eq;
  assign adj_hit   = rd_vld_r & h_r & s_kind &
                     ((row_eq & one_apart(s_col, col_r)) |
                      (col_eq & one_apart(s_row, row_r)));

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r  <= in_row[CW-1:0];
      col_r  <= in_col[CW-1:0];
      h_r    <= in_is_h;
      last_r <= in_last;
    end
  end

  // Scan index and read-data valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Conformation counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      count_r <= '0;
      adj_r   <= '0;
      bond_r  <= '0;
      prev_r  <= 1'b0;
      coll_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (same_site) begin
        coll_r <= 1'b1;
      end
      if (adj_hit && adj_r != ADJ_MAX) begin
        adj_r <= adj_r + 1'b1;
      end
      if (cmd.wr_en) begin
        count_r <= count_r + 1'b1;
        prev_r  <= h_r;
        if (count_r != '0 && h_r && prev_r && bond_r != BOND_MAX) begin
          bond_r <= bond_r + 1'b1;
        end
      end
    end
  end

  // Energy: bonded minus adjacent, clamped
  assign bond_eff     = (count_r >= CNT_MIN) ? bond_r : 7'd0;
  assign diff         = $signed({2'b00, bond_eff}) - $signed({1'b0, adj_r});
  always_comb begin
    priority if (diff < ENERGY_MIN) begin
      energy_clamp = ENERGY_MIN;
    end else if (diff > ENERGY_MAX) begin
      energy_clamp = ENERGY_MAX;
    end else begin
      energy_clamp = diff;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      energy_r   <= energy_clamp[7:0];
      coll_out_r <= coll_r;
      ovf_out_r  <= ovf_r;
    end
  end

  // Status; last follows the live field while the controller is idle
  assign status.full      = (count_r == CNT_FULL);
  assign status.scan_done = (idx_r == count_r);
  assign status.last      = cmd.load ? in_last : last_r;

  assign out_valid     = out_valid_r;
  assign out_energy    = energy_r;
  assign out_collision = coll_out_r;
  assign out_overflow  = ovf_out_r;

endmodule

FILE: rtl/hp_lattice_contact_energy_core.sv
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+------------------------------
// request   | in_row, in_col, in_is_h, in_last             | taken when start & !busy
// result    | out_energy, out_collision, out_overflow      | out_valid, one cycle, no stall
//
// A stored monomer request is compared in state SCAN with each monomer already stored, then
// written in state WRITE before busy drops; the one-port site RAM is read once per cycle.
// A request with in_last set also passes state FINISH; out_valid comes in the first cycle
// busy is low. A request that finds the store full is dropped unscanned (FINISH if in_last).
// rst_n is synchronous; it clears control and counters, the site RAM is not cleared.
// The receiver cannot stall: out_valid is a single-cycle strobe.
// Top level; depends on hlce_pkg, hlce_ctrl, hlce_dp, hlce_ram.
module hp_lattice_contact_energy_core #(
  parameter int MAX_MONOMERS = 64,
  parameter int COORD_BITS   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_row,
  input  logic [7:0]        in_col,
  input  logic              in_is_h,
  input  logic              in_last,
  output logic              out_valid,
  output logic signed [7:0] out_energy,
  output logic              out_collision,
  output logic              out_overflow
);
  import hlce_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Controller
  hlce_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath
  hlce_dp #(
    .MAX_MONOMERS (MAX_MONOMERS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_is_h       (in_is_h),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_energy    (out_energy),
    .out_collision (out_collision),
    .out_overflow  (out_overflow)
  );

`ifndef ASSERT_OFF
  // Results are single-cycle strobes, one per conformation
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // No store access while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !(cmd.rd_en || cmd.wr_en || cmd.emit))
    else $error("store access or result while idle");

  // Never write past the end of the store
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !status.full)
    else $error("store write with store full");
`endif

endmodule
